### hdl/apds_pkg.sv
package apds_pkg;

  localparam int unsigned MCLK_W  = 26;
  localparam int unsigned FRAME_W = 19;
  localparam int unsigned WORD_W  = 6;
  localparam int unsigned REG_W   = 28;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned MODC_W  = 27;
  localparam int unsigned PROC_W  = 35;
  localparam int unsigned CODEC_W = 43;
  localparam int unsigned DVD_W   = 40;
  localparam int unsigned DVS_W   = 26;
  localparam int unsigned DCNT_W  = 6;

  localparam logic [CODEC_W-1:0] CODEC_MIN_HZ    = 43'd80000000;
  localparam logic [CODEC_W-1:0] CODEC_MAX_HZ    = 43'd110000000;
  localparam logic [13:0]        FRAC_SCALE      = 14'd10000;
  localparam logic [MCLK_W-1:0]  EXACT_IN_MIN_HZ = 26'd512000;
  localparam logic [MCLK_W-1:0]  IN_MAX_HZ       = 26'd20000000;
  localparam logic [MCLK_W-1:0]  FRAC_IN_MIN_HZ  = 26'd10000000;
  localparam logic [DVD_W-1:0]   J_MIN           = 40'd4;
  localparam logic [DVD_W-1:0]   J_MAX           = 40'd259;
  localparam logic [MCLK_W-1:0]  TIMER_STEP_HZ   = 26'd1000000;
  localparam logic [DVD_W-1:0]   BCLK_SAT        = 40'd1023;
  localparam logic [5:0]         TIMER_SAT       = 6'd63;

  localparam logic [REG_W-1:0] MOD_MAX_RST  = 28'd6758000;
  localparam logic [REG_W-1:0] PROC_MAX_RST = 28'd49152000;

  typedef enum logic [0:0] {
    REG_MOD_MAX  = 1'b0,
    REG_PROC_MAX = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DIV_J,
    ST_DIV_D,
    ST_POST,
    ST_DIV_B,
    ST_DIV_T,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dividend;
    logic [DVS_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DVD_W-1:0]  quot;
    logic [DVS_W-1:0]  rem;
  } div_rsp_t;

  typedef struct packed {
    logic [REG_W-1:0] mod_max;
    logic [REG_W-1:0] proc_max;
  } cfg_t;

endpackage

### hdl/apds_if.sv
interface apds_in_if;
  logic        valid;
  logic        ready;
  logic [25:0] master_clock_hz;
  logic [18:0] frame_rate_hz;
  logic [5:0]  word_bits;
  logic        bit_clock_master;

  modport source (output valid, master_clock_hz, frame_rate_hz, word_bits,
                  bit_clock_master, input ready);
  modport sink (input valid, master_clock_hz, frame_rate_hz, word_bits,
                bit_clock_master, output ready);
endinterface

interface apds_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [8:0]  pll_int;
  logic [13:0] pll_frac;
  logic [7:0]  div_n;
  logic [7:0]  div_m;
  logic [7:0]  oversample;
  logic [9:0]  bit_clock_div;
  logic [5:0]  timer_div;

  modport source (output valid, status, pll_int, pll_frac, div_n, div_m,
                  oversample, bit_clock_div, timer_div, input ready);
  modport sink (input valid, status, pll_int, pll_frac, div_n, div_m,
                oversample, bit_clock_div, timer_div, output ready);
endinterface

### hdl/audio_pll_divider_search.sv
// Audio PLL divider search.
// in_i carries one request word (master clock, frame rate, word size,
// bit-clock-master flag); out_o returns one result word per request.
// Both are valid/ready channels; a word moves when valid and ready are high.
// The two limit registers sit on the APB port, at byte addresses 0 and 4.
// in_i.ready is high only while the sequencer is idle. The search walks n,
// then m, then oversampling, one candidate per cycle with running sums
// while the divider is idle. A candidate inside the codec window goes
// through the shared restoring divider for J, and through it again for D
// when not exact and the master clock is at least 10 MHz. After the hit,
// the bit clock divider uses the same divider when enabled, and the timer
// divider does one compare-subtract step per megahertz. The search covers
// up to MAX_DIVIDER*MAX_DIVIDER*MAX_OVERSAMPLE candidates.
// A master clock outside 512 kHz to 20 MHz skips the search.
// The result waits in an output register; a new request is taken meanwhile,
// and a finished search holds until that register frees up.
// Reset clears the sequencer and output valid and restores the limits.
module audio_pll_divider_search #(
  parameter int unsigned MAX_DIVIDER    = 128,
  parameter int unsigned MAX_OVERSAMPLE = 254
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  apds_in_if.sink     in_i,
  apds_out_if.source  out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned CW = apds_pkg::CNT_W;
  localparam logic [CW-1:0] DIV_LIM = CW'(MAX_DIVIDER);
  localparam logic [CW-1:0] OS_LIM  = CW'(MAX_OVERSAMPLE);
  localparam logic [CW-1:0] ONE     = CW'(1);

  apds_pkg::cfg_t     cfg;
  apds_pkg::div_req_t div_req;
  apds_pkg::div_rsp_t div_rsp;
  apds_pkg::state_e   state_q, state_d;

  logic [apds_pkg::MCLK_W-1:0]  mclk_q, mclk_d;
  logic [apds_pkg::FRAME_W-1:0] frame_q, frame_d;
  logic [apds_pkg::WORD_W-1:0]  word_q, word_d;
  logic                         master_q, master_d;
  logic [CW-1:0]                n_q, n_d, m_q, m_d, os_q, os_d;
  logic [apds_pkg::MODC_W-1:0]  modc_q, modc_d, fn_q, fn_d;
  logic [apds_pkg::PROC_W-1:0]  proc_q, proc_d, fm_q, fm_d;
  logic [apds_pkg::CODEC_W-1:0] codec_q, codec_d, fmn_q, fmn_d;
  logic [8:0]                   j_q, j_d;
  logic [13:0]                  d_q, d_d;
  logic                         found_q, found_d;
  logic [9:0]                   bclk_q, bclk_d;
  logic [apds_pkg::MCLK_W-1:0]  tacc_q, tacc_d;
  logic [5:0]                   t_q, t_d;

  logic [CW-1:0]                a_n, a_m, a_os;
  logic [apds_pkg::MODC_W-1:0]  a_modc, a_fn;
  logic [apds_pkg::PROC_W-1:0]  a_proc, a_fm;
  logic [apds_pkg::CODEC_W-1:0] a_codec, a_fmn;
  logic                         a_end;

  logic                         pass;
  logic                         mclk_ok;
  logic [apds_pkg::DVD_W-1:0]   frac_num;

  logic        out_valid_q, out_valid_d;
  logic        o_status_q, o_status_d;
  logic [8:0]  o_j_q, o_j_d;
  logic [13:0] o_d_q, o_d_d;
  logic [7:0]  o_n_q, o_n_d, o_m_q, o_m_d, o_os_q, o_os_d;
  logic [9:0]  o_b_q, o_b_d;
  logic [5:0]  o_t_q, o_t_d;

  apds_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  apds_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign pass = ({1'b0, modc_q} <= cfg.mod_max)
             && (proc_q <= apds_pkg::PROC_W'(cfg.proc_max))
             && (codec_q >= apds_pkg::CODEC_MIN_HZ)
             && (codec_q <= apds_pkg::CODEC_MAX_HZ);

  assign mclk_ok  = (in_i.master_clock_hz >= apds_pkg::EXACT_IN_MIN_HZ)
                 && (in_i.master_clock_hz <= apds_pkg::IN_MAX_HZ);
  assign frac_num = apds_pkg::DVD_W'(div_rsp.rem) * apds_pkg::DVD_W'(apds_pkg::FRAC_SCALE);

  always_comb begin
    a_n     = n_q;
    a_m     = m_q;
    a_os    = os_q;
    a_modc  = modc_q;
    a_proc  = proc_q;
    a_codec = codec_q;
    a_fn    = fn_q;
    a_fm    = fm_q;
    a_fmn   = fmn_q;
    a_end   = 1'b0;
    if (os_q < OS_LIM) begin
      a_os    = os_q + 1'b1;
      a_modc  = modc_q + apds_pkg::MODC_W'(frame_q);
      a_proc  = proc_q + fm_q;
      a_codec = codec_q + fmn_q;
    end else if (m_q < DIV_LIM) begin
      a_m     = m_q + 1'b1;
      a_os    = ONE;
      a_fm    = fm_q + apds_pkg::PROC_W'(frame_q);
      a_fmn   = fmn_q + apds_pkg::CODEC_W'(fn_q);
      a_modc  = apds_pkg::MODC_W'(frame_q);
      a_proc  = fm_q + apds_pkg::PROC_W'(frame_q);
      a_codec = fmn_q + apds_pkg::CODEC_W'(fn_q);
    end else if (n_q < DIV_LIM) begin
      a_n     = n_q + 1'b1;
      a_m     = ONE;
      a_os    = ONE;
      a_fn    = fn_q + apds_pkg::MODC_W'(frame_q);
      a_fm    = apds_pkg::PROC_W'(frame_q);
      a_fmn   = apds_pkg::CODEC_W'(fn_q) + apds_pkg::CODEC_W'(frame_q);
      a_modc  = apds_pkg::MODC_W'(frame_q);
      a_proc  = apds_pkg::PROC_W'(frame_q);
      a_codec = apds_pkg::CODEC_W'(fn_q) + apds_pkg::CODEC_W'(frame_q);
    end else begin
      a_end = 1'b1;
    end
  end

  always_comb begin
    state_d  = state_q;
    mclk_d   = mclk_q;
    frame_d  = frame_q;
    word_d   = word_q;
    master_d = master_q;
    n_d      = n_q;
    m_d      = m_q;
    os_d     = os_q;
    modc_d   = modc_q;
    proc_d   = proc_q;
    codec_d  = codec_q;
    fn_d     = fn_q;
    fm_d     = fm_q;
    fmn_d    = fmn_q;
    j_d      = j_q;
    d_d      = d_q;
    found_d  = found_q;
    bclk_d   = bclk_q;
    tacc_d   = tacc_q;
    t_d      = t_q;
    div_req  = '0;
    in_i.ready = 1'b0;
    out_valid_d = out_valid_q && !out_o.ready;
    o_status_d = o_status_q;
    o_j_d = o_j_q;
    o_d_d = o_d_q;
    o_n_d = o_n_q;
    o_m_d = o_m_q;
    o_os_d = o_os_q;
    o_b_d = o_b_q;
    o_t_d = o_t_q;

    case (state_q)
      apds_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          mclk_d   = in_i.master_clock_hz;
          frame_d  = in_i.frame_rate_hz;
          word_d   = in_i.word_bits;
          master_d = in_i.bit_clock_master;
          n_d      = ONE;
          m_d      = ONE;
          os_d     = ONE;
          modc_d   = apds_pkg::MODC_W'(in_i.frame_rate_hz);
          fn_d     = apds_pkg::MODC_W'(in_i.frame_rate_hz);
          proc_d   = apds_pkg::PROC_W'(in_i.frame_rate_hz);
          fm_d     = apds_pkg::PROC_W'(in_i.frame_rate_hz);
          codec_d  = apds_pkg::CODEC_W'(in_i.frame_rate_hz);
          fmn_d    = apds_pkg::CODEC_W'(in_i.frame_rate_hz);
          found_d  = 1'b0;
          state_d  = mclk_ok ? apds_pkg::ST_SEARCH : apds_pkg::ST_EMIT;
        end
      end
      apds_pkg::ST_SEARCH: begin
        if (pass) begin
          div_req.start    = 1'b1;
          div_req.dividend = codec_q[apds_pkg::DVD_W-1:0];
          div_req.divisor  = mclk_q;
          state_d          = apds_pkg::ST_DIV_J;
        end else begin
          n_d = a_n; m_d = a_m; os_d = a_os;
          modc_d = a_modc; proc_d = a_proc; codec_d = a_codec;
          fn_d = a_fn; fm_d = a_fm; fmn_d = a_fmn;
          if (a_end) begin
            state_d = apds_pkg::ST_EMIT;
          end
        end
      end
      apds_pkg::ST_DIV_J: begin
        if (div_rsp.done) begin
          j_d = div_rsp.quot[8:0];
          d_d = '0;
          if (div_rsp.rem == '0) begin
            if (div_rsp.quot >= apds_pkg::J_MIN && div_rsp.quot <= apds_pkg::J_MAX) begin
              found_d = 1'b1;
              state_d = apds_pkg::ST_POST;
            end else begin
              state_d = apds_pkg::ST_SEARCH;
            end
          end else if (div_rsp.quot != '0 && mclk_q >= apds_pkg::FRAC_IN_MIN_HZ) begin
            div_req.start    = 1'b1;
            div_req.dividend = frac_num;
            div_req.divisor  = mclk_q;
            state_d          = apds_pkg::ST_DIV_D;
          end else begin
            state_d = apds_pkg::ST_SEARCH;
          end
          if (state_d == apds_pkg::ST_SEARCH) begin
            n_d = a_n; m_d = a_m; os_d = a_os;
            modc_d = a_modc; proc_d = a_proc; codec_d = a_codec;
            fn_d = a_fn; fm_d = a_fm; fmn_d = a_fmn;
            if (a_end) begin
              state_d = apds_pkg::ST_EMIT;
            end
          end
        end
      end
      apds_pkg::ST_DIV_D: begin
        if (div_rsp.done) begin
          d_d     = div_rsp.quot[13:0];
          found_d = 1'b1;
          state_d = apds_pkg::ST_POST;
        end
      end
      apds_pkg::ST_POST: begin
        if (master_q && word_q != '0) begin
          div_req.start    = 1'b1;
          div_req.dividend = apds_pkg::DVD_W'(os_q * m_q);
          div_req.divisor  = apds_pkg::DVS_W'({word_q, 1'b0});
          state_d          = apds_pkg::ST_DIV_B;
        end else begin
          bclk_d  = master_q ? 10'd0 : 10'd1;
          tacc_d  = mclk_q;
          t_d     = '0;
          state_d = apds_pkg::ST_DIV_T;
        end
      end
      apds_pkg::ST_DIV_B: begin
        if (div_rsp.done) begin
          bclk_d = (div_rsp.quot > apds_pkg::BCLK_SAT) ? 10'd1023 : div_rsp.quot[9:0];
          tacc_d  = mclk_q;
          t_d     = '0;
          state_d = apds_pkg::ST_DIV_T;
        end
      end
      apds_pkg::ST_DIV_T: begin
        if (tacc_q == '0 || t_q == apds_pkg::TIMER_SAT) begin
          state_d = apds_pkg::ST_EMIT;
        end else begin
          t_d    = t_q + 1'b1;
          tacc_d = (tacc_q > apds_pkg::TIMER_STEP_HZ) ? tacc_q - apds_pkg::TIMER_STEP_HZ
                                                      : '0;
        end
      end
      apds_pkg::ST_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          o_status_d  = !found_q;
          o_j_d       = found_q ? j_q : '0;
          o_d_d       = found_q ? d_q : '0;
          o_n_d       = found_q ? n_q : '0;
          o_m_d       = found_q ? m_q : '0;
          o_os_d      = found_q ? os_q : '0;
          o_b_d       = found_q ? bclk_q : '0;
          o_t_d       = found_q ? t_q : '0;
          state_d = apds_pkg::ST_IDLE;
        end
      end
      default: state_d = apds_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= apds_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      found_q     <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mclk_q   <= mclk_d;
    frame_q  <= frame_d;
    word_q   <= word_d;
    master_q <= master_d;
    n_q      <= n_d;
    m_q      <= m_d;
    os_q     <= os_d;
    modc_q   <= modc_d;
    proc_q   <= proc_d;
    codec_q  <= codec_d;
    fn_q     <= fn_d;
    fm_q     <= fm_d;
    fmn_q    <= fmn_d;
    j_q      <= j_d;
    d_q      <= d_d;
    bclk_q   <= bclk_d;
    tacc_q   <= tacc_d;
    t_q      <= t_d;
    o_status_q <= o_status_d;
    o_j_q    <= o_j_d;
    o_d_q    <= o_d_d;
    o_n_q    <= o_n_d;
    o_m_q    <= o_m_d;
    o_os_q   <= o_os_d;
    o_b_q    <= o_b_d;
    o_t_q    <= o_t_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = o_status_q;
  assign out_o.pll_int       = o_j_q;
  assign out_o.pll_frac      = o_d_q;
  assign out_o.div_n         = o_n_q;
  assign out_o.div_m         = o_m_q;
  assign out_o.oversample    = o_os_q;
  assign out_o.bit_clock_div = o_b_q;
  assign out_o.timer_div     = o_t_q;

`ifndef SYNTHESIS
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");
  a_hit_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !o_status_q |-> o_n_q != '0 && o_m_q != '0 && o_os_q != '0)
    else $error("found result with zero divider");
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && o_status_q |-> o_j_q == '0 && o_n_q == '0 && o_t_q == '0)
    else $error("failed result carries nonzero fields");
  a_search_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == apds_pkg::ST_SEARCH |-> n_q != '0 && m_q != '0 && os_q != '0)
    else $error("search counter at zero");
`endif

endmodule

### hdl/apds_div.sv
module apds_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  apds_pkg::div_req_t  req_i,
  output apds_pkg::div_rsp_t  rsp_o
);

  logic                        active_q, active_d;
  logic                        done_q, done_d;
  logic [apds_pkg::DCNT_W-1:0] cnt_q, cnt_d;
  logic [apds_pkg::DVD_W-1:0]  quo_q, quo_d;
  logic [apds_pkg::DVS_W-1:0]  rem_q, rem_d;
  logic [apds_pkg::DVS_W-1:0]  dvs_q, dvs_d;
  logic [apds_pkg::DVS_W:0]    trial;
  logic                        take;

  assign trial = {rem_q, quo_q[apds_pkg::DVD_W-1]};
  assign take  = trial >= {1'b0, dvs_q};

  always_comb begin
    active_d = active_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    quo_d    = quo_q;
    rem_d    = rem_q;
    dvs_d    = dvs_q;
    if (req_i.start) begin
      active_d = 1'b1;
      cnt_d    = apds_pkg::DCNT_W'(apds_pkg::DVD_W);
      quo_d    = req_i.dividend;
      rem_d    = '0;
      dvs_d    = req_i.divisor;
    end else if (active_q) begin
      rem_d = take ? apds_pkg::DVS_W'(trial - {1'b0, dvs_q})
                   : trial[apds_pkg::DVS_W-1:0];
      quo_d = {quo_q[apds_pkg::DVD_W-2:0], take};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == apds_pkg::DCNT_W'(1)) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy = active_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

### hdl/apds_cfg.sv
module apds_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output apds_pkg::cfg_t     cfg_o
);

  logic [apds_pkg::REG_W-1:0] mod_max_q, mod_max_d;
  logic [apds_pkg::REG_W-1:0] proc_max_q, proc_max_d;
  apds_pkg::reg_idx_e         idx;
  logic                       wr;

  assign idx    = apds_pkg::reg_idx_e'(paddr[2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    mod_max_d  = mod_max_q;
    proc_max_d = proc_max_q;
    if (wr) begin
      case (idx)
        apds_pkg::REG_MOD_MAX:  mod_max_d  = pwdata[apds_pkg::REG_W-1:0];
        apds_pkg::REG_PROC_MAX: proc_max_d = pwdata[apds_pkg::REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      apds_pkg::REG_MOD_MAX:  prdata = 32'(mod_max_q);
      apds_pkg::REG_PROC_MAX: prdata = 32'(proc_max_q);
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_max_q  <= apds_pkg::MOD_MAX_RST;
      proc_max_q <= apds_pkg::PROC_MAX_RST;
    end else begin
      mod_max_q  <= mod_max_d;
      proc_max_q <= proc_max_d;
    end
  end

  assign cfg_o.mod_max  = mod_max_q;
  assign cfg_o.proc_max = proc_max_q;

endmodule
